// File: src/b2s_pkg.sv
package b2s_pkg;

  // Largest value the four-digit display can show
  localparam int unsigned MagWidth = 14;
  localparam logic [MagWidth-1:0] DisplayMax = 14'd9999;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned BcdWidth   = 4 * DigitCount;
  localparam int unsigned SegWidth   = 7;

  typedef logic [BcdWidth-1:0] bcd_t;
  typedef logic [SegWidth-1:0] seg_t;
  typedef logic [MagWidth-1:0] mag_t;

  // Segment pattern for one decimal digit, bit 0 is segment a.
  // Codes above nine wrap back onto the decimal digits.
  function automatic seg_t seg_lookup(input logic [3:0] digit);
    seg_t pattern;
    case (digit)
      4'd0, 4'd10: pattern = 7'h3F;
      4'd1, 4'd11: pattern = 7'h06;
      4'd2, 4'd12: pattern = 7'h5B;
      4'd3, 4'd13: pattern = 7'h4F;
      4'd4, 4'd14: pattern = 7'h66;
      4'd5, 4'd15: pattern = 7'h6D;
      4'd6:        pattern = 7'h7D;
      4'd7:        pattern = 7'h07;
      4'd8:        pattern = 7'h7F;
      4'd9:        pattern = 7'h6F;
      default:     pattern = 7'h3F;
    endcase
    return pattern;
  endfunction

endpackage

// File: src/b2s_bcd.sv
module b2s_bcd (
  input  logic [15:0]       value,
  output b2s_pkg::bcd_t     bcd
);
  import b2s_pkg::*;

  mag_t                       mag;
  logic [BcdWidth+MagWidth-1:0] scratch;

  // Clamp: negatives and values past the display range show all nines
  always_comb begin
    if (value[15] || (value[14:0] > {1'b0, DisplayMax})) begin
      mag = DisplayMax;
    end else begin
      mag = value[MagWidth-1:0];
    end
  end

  // Shift-and-add-three array, one row per input bit
  always_comb begin
    scratch = {{BcdWidth{1'b0}}, mag};
    for (int step = 0; step < MagWidth; step++) begin
      for (int d = 0; d < DigitCount; d++) begin
        if (scratch[MagWidth + 4*d +: 4] >= 4'd5) begin
          scratch[MagWidth + 4*d +: 4] = scratch[MagWidth + 4*d +: 4] + 4'd3;
        end
      end
      scratch = {scratch[BcdWidth+MagWidth-2:0], 1'b0};
    end
    bcd = scratch[BcdWidth+MagWidth-1 -: BcdWidth];
  end

endmodule

// File: src/b2s_seg.sv
module b2s_seg (
  input  b2s_pkg::bcd_t bcd,
  output b2s_pkg::seg_t seg_thousands,
  output b2s_pkg::seg_t seg_hundreds,
  output b2s_pkg::seg_t seg_tens,
  output b2s_pkg::seg_t seg_ones
);
  import b2s_pkg::*;

  // Map each digit through the character table
  assign seg_thousands = seg_lookup(bcd[15:12]);
  assign seg_hundreds  = seg_lookup(bcd[11:8]);
  assign seg_tens      = seg_lookup(bcd[7:4]);
  assign seg_ones      = seg_lookup(bcd[3:0]);

endmodule

// File: src/binary_to_seven_segment_decimal.sv
// An accepted input word passes the input register, then the result register, to m_tdata.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous, active high) clears both valid flags; the data
// registers in_value and m_tdata are not reset.
module binary_to_seven_segment_decimal (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [15:0] bcd_word, [22:16] seg_thousands,
                                 // [29:23] seg_hundreds, [36:30] seg_tens,
                                 // [43:37] seg_ones, [47:44] zero
);
  import b2s_pkg::*;

  logic        in_valid;
  logic [15:0] in_value;
  logic        out_advance;
  logic        in_advance;

  bcd_t bcd;
  seg_t seg_thousands;
  seg_t seg_hundreds;
  seg_t seg_tens;
  seg_t seg_ones;

  // Move a stage when the one after it can take its word
  assign out_advance = !m_tvalid || m_tready;
  assign in_advance  = !in_valid || out_advance;
  assign s_tready    = in_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && s_tvalid) begin
      in_value <= s_tdata;
    end
  end

  b2s_bcd u_bcd (
    .value (in_value),
    .bcd   (bcd)
  );

  b2s_seg u_seg (
    .bcd           (bcd),
    .seg_thousands (seg_thousands),
    .seg_hundreds  (seg_hundreds),
    .seg_tens      (seg_tens),
    .seg_ones      (seg_ones)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      m_tdata <= {4'b0, seg_ones, seg_tens, seg_hundreds, seg_thousands, bcd};
    end
  end

endmodule
